// ===== sv/rfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants of the remote frame decoder: frame layout,
// sync bytes, channel mapping constants and the decoded command record.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

  // Frame layout
  localparam int FrameBytes = 22;
  localparam logic [7:0] SyncA = 8'h0A;
  localparam logic [7:0] SyncB = 8'h0D;

  // Byte offsets of the channel words (big-endian, offset of high byte)
  localparam int OffRightX = 8;
  localparam int OffRightY = 6;
  localparam int OffLeftX  = 2;
  localparam int OffLeftY  = 4;
  localparam int OffProp   = 16;
  localparam int OffRoller = 10;
  localparam int OffTop    = 12;
  localparam int OffSwA    = 18;
  localparam int OffSwB    = 19;

  // Joystick dead zone and scale
  localparam logic signed [17:0] StickLow  = 18'sd12000;
  localparam logic signed [17:0] StickHigh = 18'sd14000;
  localparam logic [16:0] StickSpan = 17'd11000;
  localparam logic [15:0] StickFull = 16'd16384;
  // ceil(2^35 / 1375): x * 2048 / 1375 == (x * StickRecip) >> 24 for x < 11000
  localparam logic [24:0] StickRecip = 25'd24988901;
  localparam int StickShift = 24;

  // Speed mapping
  localparam logic signed [15:0] SpeedLow  = 16'sd1000;
  localparam logic signed [15:0] SpeedHigh = 16'sd25000;
  localparam logic [9:0] SpeedMax = 10'd750;

  // Switch bit patterns and selector codes
  localparam logic [1:0] Pat00 = 2'b00;
  localparam logic [1:0] Pat01 = 2'b01;
  localparam logic [1:0] Pat10 = 2'b10;
  localparam logic [1:0] Sel0 = 2'd0;
  localparam logic [1:0] Sel1 = 2'd1;
  localparam logic [1:0] Sel2 = 2'd2;

  // Output packing
  localparam int OutBits = 112;

  typedef logic [FrameBytes-1:0][7:0] window_t;

  typedef struct packed {
    logic shift;  // byte beat accepted
    logic take;   // pending frame moves to the output register
  } win_ctrl_t;

  typedef struct packed {
    logic [4:0]         toggle_bits;
    logic [1:0]         mode_sel;
    logic [1:0]         screw_sel;
    logic [1:0]         pose_sel;
    logic [9:0]         top_pwm;
    logic [9:0]         roller_pwm;
    logic [9:0]         prop_pwm;
    logic signed [15:0] left_y;
    logic signed [15:0] left_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_x;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/rfd_window.sv =====
// ----------------------------------------------------------------------------
// rfd_window
// Shift window over the last FrameBytes received bytes, with a pending flag
// that marks a window holding a complete frame not yet decoded.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_window
  import rfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire win_ctrl_t ctrl,
  input  wire logic [7:0] rx_byte,
  output window_t        window,
  output logic           pend
);

  logic hit_next;

  // Frame check on the window as it will be after the shift
  assign hit_next = (window[1] == SyncA) && (window[2] == SyncB) &&
                    (window[FrameBytes-1] == SyncB) && (rx_byte == SyncA);

  // Window shift, offset 0 is the oldest byte
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (ctrl.shift) begin
      for (int i = 0; i < FrameBytes - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[FrameBytes-1] <= rx_byte;
    end
  end

  // Pending frame flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (ctrl.shift) begin
      pend <= hit_next;
    end else if (ctrl.take) begin
      pend <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rfd_decode.sv =====
// ----------------------------------------------------------------------------
// rfd_decode
// Decodes a framed window into one command: joystick dead-zone mapping to
// Q1.14, speed mapping to the pwm scale and the switch selectors.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_decode
  import rfd_pkg::*;
(
  input  wire window_t    window,
  input  wire logic [1:0] held_screw,
  input  wire logic [1:0] held_mode,
  output cmd_t            cmd
);

  // Dead zone, then |d| * 16384 / 11000 truncated toward zero, clamped
  function automatic logic signed [15:0] stick_map(input logic signed [15:0] v);
    logic signed [17:0] vx;
    logic signed [17:0] d_lo;
    logic signed [17:0] d_hi;
    logic [16:0] mag;
    logic [38:0] prod;
    logic [15:0] q;
    logic neg;
    vx   = {{2{v[15]}}, v};
    d_lo = StickLow - vx;
    d_hi = vx - StickHigh;
    neg  = (vx <= StickLow);
    mag  = neg ? d_lo[16:0] : d_hi[16:0];
    prod = {25'd0, mag[13:0]} * {14'd0, StickRecip};
    if (mag >= StickSpan) begin
      q = StickFull;
    end else begin
      q = {1'b0, prod[StickShift +: 15]};
    end
    if ((vx > StickLow) && (vx < StickHigh)) begin
      return 16'sd0;
    end
    return neg ? $signed(-q) : $signed(q);
  endfunction

  // Below 1000 gives 0, 25000 and up gives 750, else (v - 1000) / 32
  function automatic logic [9:0] speed_map(input logic signed [15:0] v);
    logic [15:0] diff;
    diff = v - SpeedLow;
    if (v < SpeedLow) begin
      return 10'd0;
    end
    if (v >= SpeedHigh) begin
      return SpeedMax;
    end
    return diff[14:5];
  endfunction

  logic [7:0] sw_a;
  logic [7:0] sw_b;

  assign sw_a = window[OffSwA];
  assign sw_b = window[OffSwB];

  // Channel words
  always_comb begin
    cmd.right_x    = stick_map({window[OffRightX], window[OffRightX+1]});
    cmd.right_y    = stick_map({window[OffRightY], window[OffRightY+1]});
    cmd.left_x     = stick_map({window[OffLeftX], window[OffLeftX+1]});
    cmd.left_y     = stick_map({window[OffLeftY], window[OffLeftY+1]});
    cmd.prop_pwm   = speed_map({window[OffProp], window[OffProp+1]});
    cmd.roller_pwm = speed_map({window[OffRoller], window[OffRoller+1]});
    cmd.top_pwm    = speed_map({window[OffTop], window[OffTop+1]});
    cmd.toggle_bits = sw_b[6:2];
  end

  // Switch selectors; unused pattern keeps the held screw and mode
  always_comb begin
    case (sw_a[7:6])
      Pat10:   cmd.pose_sel = Sel0;
      Pat00:   cmd.pose_sel = Sel1;
      default: cmd.pose_sel = Sel2;
    endcase
    case (sw_a[5:4])
      Pat00:   cmd.screw_sel = Sel0;
      Pat10:   cmd.screw_sel = Sel1;
      Pat01:   cmd.screw_sel = Sel2;
      default: cmd.screw_sel = held_screw;
    endcase
    case (sw_a[3:2])
      Pat10:   cmd.mode_sel = Sel0;
      Pat00:   cmd.mode_sel = Sel1;
      Pat01:   cmd.mode_sel = Sel2;
      default: cmd.mode_sel = held_mode;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/remote_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// remote_frame_decoder_top
// Radio byte stream in, one decoded remote command out per received frame.
//
// Input channel s_*: one received byte per beat. Output channel m_*: one
// decoded command per frame found in the 22-byte window (0x0A 0x0D at the
// start, 0x0D 0x0A at the end). Bytes that complete no frame give no beat.
// A command passes from the window, with its pend flag set, into the output
// register that drives m_tvalid; a stalled output keeps it waiting in the
// window. Throughput: one byte per cycle while s_tready is high. The window
// register feeds the decode logic (one 14x25 multiply per joystick) straight
// into the output register. When the receiver stalls, bytes keep being
// accepted into the window as long as no decoded frame is waiting behind the
// output register; a second frame behind a stalled output holds s_tready low
// until m_tready returns.
// Reset (rst, synchronous) clears the window to zeros, the held screw and
// mode selectors to zero and drops any pending or presented command.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_frame_decoder_top
  import rfd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,  // [7:0] rx_byte
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // [15:0] right_x, [31:16] right_y, [47:32] left_x, [63:48] left_y,
  // [73:64] prop_pwm, [83:74] roller_pwm, [93:84] top_pwm, [95:94] pose_sel,
  // [97:96] screw_sel, [99:98] mode_sel, [104:100] toggle_bits, rest zero
  output logic [OutBits-1:0]       m_tdata
);

  win_ctrl_t  ctrl;
  window_t    window;
  logic       pend;
  cmd_t       cmd;
  cmd_t       out_cmd;
  logic [1:0] held_screw;
  logic [1:0] held_mode;

  // Handshake: a pending frame moves on when the output register frees up
  assign ctrl.take  = pend && (!m_tvalid || m_tready);
  assign s_tready   = !pend || ctrl.take;
  assign ctrl.shift = s_tvalid && s_tready;

  rfd_window u_window (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .rx_byte (s_tdata),
    .window  (window),
    .pend    (pend)
  );

  rfd_decode u_decode (
    .window     (window),
    .held_screw (held_screw),
    .held_mode  (held_mode),
    .cmd        (cmd)
  );

  // Output valid and held selectors
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      held_screw <= Sel0;
      held_mode  <= Sel0;
    end else begin
      if (ctrl.take) begin
        m_tvalid   <= 1'b1;
        held_screw <= cmd.screw_sel;
        held_mode  <= cmd.mode_sel;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      out_cmd <= cmd;
    end
  end

  assign m_tdata = {{(OutBits - $bits(cmd_t)){1'b0}}, out_cmd};

endmodule

`default_nettype wire

// ===== dv/tb_remote_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_remote_frame_decoder_top
// Self-checking bench for the remote frame decoder. Byte beats go into the
// slave side: a short directed stretch of edge values, then mostly
// well-formed frames with biased channel words, broken frames, frames that
// share their leading sync byte with the previous frame's tail, and noise.
// A scoreboard keeps its own 22-byte window and held switch state. For every
// accepted byte it predicts whether a command comes out and what it holds,
// then checks each command beat field by field. Both sides idle at random,
// and once the receiver holds off long enough to back-pressure the input.
// ----------------------------------------------------------------------------

module tb_remote_frame_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rfd_pkg::*;

  typedef logic [7:0] frame_t [FrameBytes];

  logic               clk;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OutBits-1:0] m_tdata;

  logic [7:0] last_byte = '0;

  remote_frame_decoder_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Scoreboard: frame window, held switches and commands still owed
  class command_scoreboard;
    logic [7:0] window [FrameBytes];
    logic [1:0] held_screw;
    logic [1:0] held_mode;
    cmd_t       pending_cmds[$];
    int         errors;
    int         frames_found;
    int         cmds_seen;

    function new();
      foreach (window[i]) window[i] = '0;
      held_screw = Sel0;
      held_mode = Sel0;
      errors = 0;
      frames_found = 0;
      cmds_seen = 0;
    endfunction

    // Big-endian channel word at a frame offset, as a signed value
    function int word_at(int off);
      logic signed [15:0] w;
      w = {window[off], window[off + 1]};
      return int'(w);
    endfunction

    // Dead zone 12000..14000, scale 16384/11000 toward zero, clamp to +-1.0
    function logic signed [15:0] stick_to_q14(int v);
      int r;
      if (v > 12000 && v < 14000) return '0;
      if (v <= 12000) r = ((v - 12000) * 16384) / 11000;
      else r = ((v - 14000) * 16384) / 11000;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
    endfunction

    function logic [9:0] speed_to_pwm(int v);
      int r;
      if (v < 1000) return '0;
      if (v >= 25000) return SpeedMax;
      r = (v - 1000) / 32;
      return r[9:0];
    endfunction

    // Shift one accepted byte in and queue a command if a frame lines up
    function void push_byte(logic [7:0] b);
      cmd_t       c;
      logic [7:0] sw_a;
      logic [1:0] pat;
      for (int i = 0; i < FrameBytes - 1; i++) window[i] = window[i + 1];
      window[FrameBytes - 1] = b;
      if (!(window[0] == SyncA && window[1] == SyncB &&
            window[FrameBytes - 2] == SyncB && window[FrameBytes - 1] == SyncA))
        return;
      sw_a = window[OffSwA];
      pat = sw_a[7:6];
      c.pose_sel = (pat == Pat10) ? Sel0 : (pat == Pat00) ? Sel1 : Sel2;
      pat = sw_a[5:4];
      case (pat)
        Pat00:   c.screw_sel = Sel0;
        Pat10:   c.screw_sel = Sel1;
        Pat01:   c.screw_sel = Sel2;
        default: c.screw_sel = held_screw;
      endcase
      pat = sw_a[3:2];
      case (pat)
        Pat10:   c.mode_sel = Sel0;
        Pat00:   c.mode_sel = Sel1;
        Pat01:   c.mode_sel = Sel2;
        default: c.mode_sel = held_mode;
      endcase
      held_screw = c.screw_sel;
      held_mode = c.mode_sel;
      c.right_x = stick_to_q14(word_at(OffRightX));
      c.right_y = stick_to_q14(word_at(OffRightY));
      c.left_x = stick_to_q14(word_at(OffLeftX));
      c.left_y = stick_to_q14(word_at(OffLeftY));
      c.prop_pwm = speed_to_pwm(word_at(OffProp));
      c.roller_pwm = speed_to_pwm(word_at(OffRoller));
      c.top_pwm = speed_to_pwm(word_at(OffTop));
      c.toggle_bits = window[OffSwB][6:2];
      pending_cmds.push_back(c);
      frames_found++;
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        errors++;
        $error("%s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_command(logic [OutBits-1:0] beat);
      cmd_t got;
      cmd_t want;
      got = beat[$bits(cmd_t)-1:0];
      cmds_seen++;
      if (pending_cmds.size() == 0) begin
        errors++;
        $error("command beat with no frame pending: %h", beat);
        return;
      end
      want = pending_cmds.pop_front();
      compare_field("right_x", want.right_x, got.right_x);
      compare_field("right_y", want.right_y, got.right_y);
      compare_field("left_x", want.left_x, got.left_x);
      compare_field("left_y", want.left_y, got.left_y);
      compare_field("prop_pwm", want.prop_pwm, got.prop_pwm);
      compare_field("roller_pwm", want.roller_pwm, got.roller_pwm);
      compare_field("top_pwm", want.top_pwm, got.top_pwm);
      compare_field("pose_sel", want.pose_sel, got.pose_sel);
      compare_field("screw_sel", want.screw_sel, got.screw_sel);
      compare_field("mode_sel", want.mode_sel, got.mode_sel);
      compare_field("toggle_bits", want.toggle_bits, got.toggle_bits);
      compare_field("pad", 0, beat[OutBits-1:$bits(cmd_t)]);
    endfunction

    function void check_drained();
      if (pending_cmds.size() != 0) begin
        errors++;
        $error("%0d decoded commands never came out", pending_cmds.size());
      end
    endfunction
  endclass

  command_scoreboard cmd_board = new();

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Channel word biased toward the map thresholds and the word extremes
  function automatic logic [15:0] pick_word();
    int centers [7] = '{1000, 12000, 14000, 25000, 0, 32767, -32768};
    int v;
    if ($urandom_range(0, 9) < 3) return 16'($urandom_range(0, 16'hFFFF));
    v = centers[$urandom_range(0, 6)];
    if ($urandom_range(0, 3) == 0) v += $urandom_range(0, 80) - 40;
    else v += $urandom_range(0, 6) - 3;
    return v[15:0];
  endfunction

  function automatic void make_frame(output frame_t frm);
    logic [15:0] w;
    for (int off = 2; off < OffSwA; off += 2) begin
      w = pick_word();
      frm[off] = w[15:8];
      frm[off + 1] = w[7:0];
    end
    frm[0] = SyncA;
    frm[1] = SyncB;
    frm[OffSwA] = 8'($urandom_range(0, 255));
    frm[OffSwB] = 8'($urandom_range(0, 255));
    frm[FrameBytes - 2] = SyncB;
    frm[FrameBytes - 1] = SyncA;
  endfunction

  // One byte beat; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    cmd_board.push_byte(b);
    last_byte = b;
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_t frm, input int first, input bit burst);
    for (int i = first; i < FrameBytes; i++)
      send_byte(frm[i], burst ? 0 : pick_gap());
  endtask

  // Result monitor
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) cmd_board.check_command(m_tdata);
    end
  end

  // Receiver: random stalls and ready runs, plus one long hold-off
  initial begin
    int  stall_left;
    int  ready_run;
    bit  long_hold_done;
    stall_left = 0;
    ready_run = 0;
    long_hold_done = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!long_hold_done && cmd_board.cmds_seen >= 6) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        long_hold_done = 1'b1;
      end
      if (stall_left == 0 && ready_run == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          ready_run = $urandom_range(20, 80);
        end else begin
          stall_left = pick_gap();
          if (stall_left == 0) ready_run = 1;
        end
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        ready_run--;
      end
    end
  end

  // Stimulus
  initial begin
    frame_t   frm;
    int       frame_bytes;
    int       kind;
    int       wait_cnt;
    int       sync_pos [4];
    bit       burst;
    frame_bytes = 0;
    sync_pos = '{0, 1, FrameBytes - 2, FrameBytes - 1};
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: byte extremes while the window fills, then one frame with
    // word extremes, threshold words, unused switch pattern and spare bits
    send_byte(8'hFF, 0);
    send_byte(8'h00, 0);
    frm = '{SyncA, SyncB,
            8'h80, 8'h00,   // left_x  -32768
            8'h7F, 8'hFF,   // left_y  32767
            8'h2E, 8'hE0,   // right_y 12000
            8'h36, 8'hB0,   // right_x 14000
            8'h03, 8'hE7,   // roller  999
            8'h61, 8'hA8,   // top     25000
            8'hFF, 8'hFF,   // unused word
            8'h03, 8'hE8,   // prop    1000
            8'hFF, 8'hFF,   // switches: pattern 11 everywhere, all flags
            SyncB, SyncA};
    send_frame(frm, 0, 1'b1);

    // Random: mostly good frames, some chained, broken or noise
    while (frame_bytes < 700 || cmd_board.frames_found < 40) begin
      kind = $urandom_range(0, 99);
      burst = ($urandom_range(0, 3) == 0);
      make_frame(frm);
      if (kind < 65) begin
        send_frame(frm, 0, burst);
        frame_bytes += FrameBytes;
      end else if (kind < 80) begin
        // chained frame reuses the previous closing sync byte as its opener
        send_frame(frm, (last_byte == SyncA) ? 1 : 0, burst);
        frame_bytes += FrameBytes;
      end else if (kind < 92) begin
        frm[sync_pos[$urandom_range(0, 3)]] ^= 8'($urandom_range(1, 255));
        send_frame(frm, 0, burst);
        frame_bytes += FrameBytes;
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 2) == 0)
            send_byte($urandom_range(0, 1) ? SyncA : SyncB, pick_gap());
          else
            send_byte(8'($urandom_range(0, 255)), pick_gap());
        end
      end
    end
    s_tvalid <= 1'b0;

    // Drain and let the pipeline settle
    for (wait_cnt = 0; wait_cnt < 5000 && cmd_board.pending_cmds.size() != 0; wait_cnt++)
      @(negedge clk);
    repeat (8) @(negedge clk);
    cmd_board.check_drained();
    if (cmd_board.errors == 0) begin
      $display("[remote_frame_decoder_top] OK");
    end else begin
      $display("[remote_frame_decoder_top] ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #1000000;
    $display("[remote_frame_decoder_top] ERROR");
    $finish;
  end

endmodule
